/* sv/lpbt_pkg.sv */
// Shared types, sizes and codes for the linear-probe block table.
// No dependencies; every other file of the block but lpbt_ram imports this package.
`default_nettype none

package lpbt_pkg;

  // Table geometry and field widths.
  localparam int TABLE_BITS  = 12;
  localparam int TAG_BITS    = 16;
  localparam int HANDLE_BITS = 16;

  localparam int SLOT_COUNT = 1 << TABLE_BITS;
  localparam int CNT_BITS   = TABLE_BITS + 1;

  // Port field widths.
  localparam int OP_BITS     = 2;
  localparam int ADDR_BITS   = 32;
  localparam int OUT_HANDLE  = 16;
  localparam int OUT_COUNT   = 13;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 32;

  // Fibonacci hash multiplier.
  localparam logic [31:0] HASH_MULT = 32'h9E37_79B1;

  // Load limit: an insert first clears the table at three-quarter load.
  localparam logic [CNT_BITS-1:0] LOAD_LIMIT = CNT_BITS'(SLOT_COUNT * 3 / 4);

  // The first live generation; zero is never live.
  localparam logic [TAG_BITS-1:0] GEN_ONE = TAG_BITS'(1);

  // Queue between the front and back parts (depth is a power of two).
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  // Operation codes.
  localparam logic [OP_BITS-1:0] OP_FIND   = 2'd0;
  localparam logic [OP_BITS-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_BITS-1:0] OP_CLEAR  = 2'd2;
  localparam logic [OP_BITS-1:0] OP_NONE   = 2'd3;

  // One classified item as it waits in the queue.
  typedef struct packed {
    logic [OP_BITS-1:0]    op;
    logic [ADDR_BITS-1:0]  addr;
    logic [TABLE_BITS-1:0] home;
  } item_t;

  // One table slot as stored in the slot memory.
  typedef struct packed {
    logic [ADDR_BITS-1:0]   key;
    logic [TAG_BITS-1:0]    tag;
    logic [HANDLE_BITS-1:0] handle;
  } slot_t;

  localparam int SLOT_WIDTH = $bits(slot_t);

  // One result beat.
  typedef struct packed {
    logic                  auto_cleared;
    logic [OUT_COUNT-1:0]  live_count;
    logic [OUT_HANDLE-1:0] block_handle;
    logic                  hit;
  } result_t;

endpackage

`default_nettype wire

/* sv/lpbt_ram.sv */
// Generic single-port RAM with a registered read.
// No dependencies.
`default_nettype none

module lpbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port share one address.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

/* sv/lpbt_front.sv */
// Front part: accepts input beats, hashes the address to its home slot.
// Depends on lpbt_pkg.
`default_nettype none

module lpbt_front import lpbt_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  input  wire logic [OP_BITS-1:0]    in_op,
  input  wire logic [ADDR_BITS-1:0]  in_addr,
  output      logic                  push_valid,
  input  wire logic                  push_ready,
  output      item_t                 push_item
);

  logic        busy;
  item_t       item;
  logic [31:0] product;

  // Hash of the word address, modulo 2^32; the home slot is its top bits.
  assign product = {2'b00, in_addr[ADDR_BITS-1:2]} * HASH_MULT;

  assign in_ready   = !busy || push_ready;
  assign push_valid = busy;
  assign push_item  = item;

  // One register stage between the input port and the queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (in_valid && in_ready) begin
      busy <= 1'b1;
    end else if (push_ready) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.op   <= in_op;
      item.addr <= in_addr;
      item.home <= product[31 -: TABLE_BITS];
    end
  end

endmodule

`default_nettype wire

/* sv/lpbt_queue.sv */
// Short queue of classified items between the front and back parts.
// Depends on lpbt_pkg.
`default_nettype none

module lpbt_queue import lpbt_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push_valid,
  output      logic  push_ready,
  input  wire item_t push_item,
  output      logic  pop_valid,
  input  wire logic  pop,
  output      item_t pop_item
);

  item_t                entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wptr;
  logic [QPTR_BITS-1:0] rptr;
  logic [QPTR_BITS:0]   fill;
  logic                 do_push;
  logic                 do_pop;

  assign push_ready = fill != (QPTR_BITS + 1)'(QUEUE_DEPTH);
  assign pop_valid  = fill != '0;
  assign pop_item   = entries[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

/* sv/lpbt_back.sv */
// Back part: probes the slot memory, updates the table and holds the result beat.
// Depends on lpbt_pkg and lpbt_ram.
`default_nettype none

module lpbt_back import lpbt_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    q_valid,
  output      logic    q_pop,
  input  wire item_t   q_item,
  output      logic    res_valid,
  input  wire logic    res_ready,
  output      result_t res
);

  localparam logic [1:0] ST_SWEEP = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;
  localparam logic [1:0] ST_CHECK = 2'd3;

  localparam logic [TABLE_BITS-1:0] SLOT_LAST = TABLE_BITS'(SLOT_COUNT - 1);

  logic [1:0]             state;
  logic [TABLE_BITS-1:0]  sweep_idx;
  logic                   resume;
  logic [TAG_BITS-1:0]    gen;
  logic [CNT_BITS-1:0]    cnt;
  logic [HANDLE_BITS-1:0] nh;

  logic [OP_BITS-1:0]     cur_op;
  logic [ADDR_BITS-1:0]   cur_addr;
  logic [TABLE_BITS-1:0]  idx;
  logic [TABLE_BITS-1:0]  n;
  logic                   cleared;

  logic                   ram_we;
  logic                   ram_re;
  logic [TABLE_BITS-1:0]  ram_addr;
  slot_t                  ram_wdata;
  slot_t                  ram_rdata;

  logic                   out_free;
  logic                   res_load;
  logic                   over_limit;
  logic [TAG_BITS-1:0]    gen_inc;
  logic                   gen_wrap;
  logic                   slot_dead;
  logic                   slot_match;
  logic                   chk_write;
  logic                   chk_done;
  logic                   chk_hit;
  logic [HANDLE_BITS-1:0] chk_handle;
  logic [CNT_BITS-1:0]    chk_cnt;

  logic [HANDLE_BITS+OUT_HANDLE-1:0] handle_ext;
  logic [CNT_BITS+OUT_COUNT-1:0]     cnt_ext;

  lpbt_ram #(
    .WIDTH(SLOT_WIDTH),
    .DEPTH(SLOT_COUNT)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .re   (ram_re),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  // Generation step used by both an explicit and a load-limit clear.
  assign gen_inc    = gen + 1'b1;
  assign gen_wrap   = gen_inc == '0;
  assign over_limit = cnt >= LOAD_LIMIT;

  assign out_free = !res_valid || res_ready;
  assign q_pop    = (state == ST_IDLE) && q_valid && out_free;

  // A result is loaded by a clear or unknown operation at dispatch, or by a finished probe.
  assign res_load = (q_pop && (q_item.op != OP_FIND) && (q_item.op != OP_INSERT)) ||
                    ((state == ST_CHECK) && chk_done);

  // Decision on the slot whose data the memory returns.
  always_comb begin
    slot_dead  = ram_rdata.tag != gen;
    slot_match = ram_rdata.key == cur_addr;
    chk_write  = 1'b0;
    chk_done   = 1'b0;
    chk_hit    = 1'b0;
    chk_handle = '0;
    chk_cnt    = cnt;
    if (cur_op == OP_INSERT) begin
      if (slot_dead || slot_match) begin
        chk_write  = 1'b1;
        chk_done   = 1'b1;
        chk_hit    = 1'b1;
        chk_handle = nh;
        chk_cnt    = cnt + CNT_BITS'(slot_dead);
      end
    end else begin
      if (slot_dead) begin
        chk_done = 1'b1;
      end else if (slot_match) begin
        chk_done   = 1'b1;
        chk_hit    = 1'b1;
        chk_handle = ram_rdata.handle;
      end
    end
    // A probe that has seen every slot ends; unless that last slot decides it, with a miss.
    if (n == SLOT_LAST) begin
      chk_done = 1'b1;
    end
  end

  // Fit the handle and count to the result field widths.
  assign handle_ext = {{OUT_HANDLE{1'b0}}, chk_handle};
  assign cnt_ext    = {{OUT_COUNT{1'b0}}, chk_cnt};

  // Slot memory port: the wipe sweep, probe reads and the insert write.
  always_comb begin
    ram_re    = state == ST_READ;
    ram_we    = (state == ST_SWEEP) || ((state == ST_CHECK) && chk_write);
    ram_addr  = (state == ST_SWEEP) ? sweep_idx : idx;
    ram_wdata = '0;
    if (state != ST_SWEEP) begin
      ram_wdata.key    = cur_addr;
      ram_wdata.tag    = gen;
      ram_wdata.handle = nh;
    end
  end

  // Result beat valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  // Control sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_SWEEP;
      sweep_idx <= '0;
      resume    <= 1'b0;
      gen       <= GEN_ONE;
      cnt       <= '0;
      nh        <= '0;
    end else begin
      case (state)
        ST_SWEEP: begin
          sweep_idx <= sweep_idx + 1'b1;
          if (sweep_idx == SLOT_LAST) begin
            state  <= resume ? ST_READ : ST_IDLE;
            resume <= 1'b0;
          end
        end
        ST_IDLE: begin
          if (q_pop) begin
            cur_op   <= q_item.op;
            cur_addr <= q_item.addr;
            idx      <= q_item.home;
            n        <= '0;
            cleared  <= (q_item.op == OP_INSERT) && over_limit;
            case (q_item.op)
              OP_FIND: begin
                state <= ST_READ;
              end
              OP_INSERT: begin
                if (over_limit) begin
                  cnt   <= '0;
                  nh    <= '0;
                  gen   <= gen_wrap ? GEN_ONE : gen_inc;
                  state <= gen_wrap ? ST_SWEEP : ST_READ;
                  if (gen_wrap) begin
                    resume <= 1'b1;
                  end
                end else begin
                  state <= ST_READ;
                end
              end
              OP_CLEAR: begin
                cnt <= '0;
                nh  <= '0;
                gen <= gen_wrap ? GEN_ONE : gen_inc;
                res <= '0;
                if (gen_wrap) begin
                  state <= ST_SWEEP;
                end
              end
              default: begin
                res.hit          <= 1'b0;
                res.block_handle <= '0;
                res.live_count   <= cnt[OUT_COUNT-1:0];
                res.auto_cleared <= 1'b0;
              end
            endcase
          end
        end
        ST_READ: begin
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          if (chk_write) begin
            cnt <= chk_cnt;
            nh  <= nh + 1'b1;
          end
          if (chk_done) begin
            state              <= ST_IDLE;
            res.hit            <= chk_hit;
            res.block_handle   <= handle_ext[OUT_HANDLE-1:0];
            res.live_count     <= cnt_ext[OUT_COUNT-1:0];
            res.auto_cleared   <= cleared;
          end else begin
            idx   <= idx + 1'b1;
            n     <= n + 1'b1;
            state <= ST_READ;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // Zero is never a live generation.
  assert property (@(posedge clk) disable iff (rst) gen != '0)
    else $error("generation reached zero");

  // The load limit keeps the live count at or below three-quarter load.
  assert property (@(posedge clk) disable iff (rst) cnt <= LOAD_LIMIT)
    else $error("live count above load limit");

  // Memory writes come only from the wipe sweep or a completing insert.
  assert property (@(posedge clk) disable iff (rst)
      ram_we |-> (state == ST_SWEEP) || (state == ST_CHECK && cur_op == OP_INSERT))
    else $error("unexpected slot write");

  // A probe read is always followed by its check.
  assert property (@(posedge clk) disable iff (rst) (state == ST_READ) |=> (state == ST_CHECK))
    else $error("probe read not checked");
`endif

endmodule

`default_nettype wire

/* sv/linear_probe_block_table_unit.sv */
// Top level of the linear-probe block table: front, queue and back parts.
// Depends on lpbt_pkg, lpbt_front, lpbt_queue and lpbt_back.
`default_nettype none

// The block maps a 32-bit code address to a block handle in a table of 4096
// slots held in one single-port memory. A find or insert is dispatched from the
// queue, then each slot probed takes a registered memory read and then the
// compare; a clear or an unknown operation loads its result at dispatch. After
// reset, and whenever a clear (explicit, or an insert's at the load limit) wraps
// the generation count, a wipe pass writes every slot, one per cycle; during it no
// item is processed, though the input side still takes beats until the queue
// fills. The input side takes new beats while a result waits at the output.
module linear_probe_block_table_unit import lpbt_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // s_tdata: operation [1:0], code_address [33:2], zero [39:34]
  input  wire logic                   s_tvalid,
  output      logic                   s_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,
  // m_tdata: hit [0], block_handle [16:1], live_count [29:17],
  //          auto_cleared [30], zero [31]
  output      logic                   m_tvalid,
  input  wire logic                   m_tready,
  output      logic [OUT_TDATA_W-1:0] m_tdata
);

  logic    push_valid;
  logic    push_ready;
  item_t   push_item;
  logic    q_valid;
  logic    q_pop;
  item_t   q_item;
  result_t res;

  lpbt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_op     (s_tdata[1:0]),
    .in_addr   (s_tdata[33:2]),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_item (push_item)
  );

  lpbt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_item (push_item),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_item  (q_item)
  );

  lpbt_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item),
    .res_valid(m_tvalid),
    .res_ready(m_tready),
    .res      (res)
  );

  // Pack the result beat.
  assign m_tdata = {1'b0, res.auto_cleared, res.live_count, res.block_handle, res.hit};

endmodule

`default_nettype wire
